// File: hdl/fcs_pkg.sv
`timescale 1ns / 1ps
package fcs_pkg;

  localparam int MAX_TAPS_DEF = 32;
  localparam int CFG_W        = 6;
  localparam int IDX_W        = 5;
  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int Y_W          = 38;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // kind field codes
  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                       shift;
    logic                       clear;
    logic                       coef_we;
    logic [IDX_W-1:0]           coef_idx;
    logic signed [SAMPLE_W-1:0] coef;
  } cell_ctrl_t;

endpackage

// File: hdl/fcs_cell.sv
`timescale 1ns / 1ps
module fcs_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fcs_pkg::cell_ctrl_t                 ctrl,
  input  logic                                tap_en,
  input  logic signed [fcs_pkg::SAMPLE_W-1:0] s_in,
  output logic signed [fcs_pkg::SAMPLE_W-1:0] s_out,
  input  logic signed [fcs_pkg::Y_W-1:0]      acc_in,
  output logic signed [fcs_pkg::Y_W-1:0]      acc_out
);

  localparam bit LOADABLE = (INDEX < (1 << fcs_pkg::IDX_W));

  logic signed [fcs_pkg::SAMPLE_W-1:0] s_r;
  logic signed [fcs_pkg::SAMPLE_W-1:0] tap_r;
  logic signed [fcs_pkg::PROD_W-1:0]   prod_mul;
  logic signed [fcs_pkg::PROD_W-1:0]   prod_r;
  logic signed [fcs_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [fcs_pkg::Y_W-1:0]      acc_r;
  logic signed [fcs_pkg::Y_W-1:0]      acc_nxt;
  logic                                coef_hit;

  assign coef_hit = ctrl.coef_we && LOADABLE &&
                    (ctrl.coef_idx == fcs_pkg::IDX_W'(INDEX));

  // signed product kept apart from the enable select
  assign prod_mul = tap_r * s_r;
  assign prod_nxt = tap_en ? prod_mul : '0;
  assign acc_nxt  = acc_in +
                    {{(fcs_pkg::Y_W - fcs_pkg::PROD_W){prod_r[fcs_pkg::PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r   <= '0;
      tap_r <= '0;
    end else begin
      if (ctrl.clear) begin
        s_r <= '0;
      end else if (ctrl.shift) begin
        s_r <= s_in;
      end
      if (coef_hit) begin
        tap_r <= ctrl.coef;
      end
    end
  end

  // partial sum hops one cell per cycle
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign s_out   = s_r;
  assign acc_out = acc_r;

endmodule

// File: hdl/fir_convolution_stream.sv
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// in        in_valid/in_stall  in_kind, in_tap_index, in_value, in_last_sample
// out       out_valid/out_stall out_y, out_last_output
// cfg       cfg_we             cfg_wdata (tap_count)
//
// A coefficient item is written straight into its tap. Each result is made in
// order: the line shifts, the product registers load, then the partial sum walks
// the MAX_TAPS cells. A last sample gives one result per tap in use, one after
// the other; the input stalls until the final one.
// Reset (synchronous) zeroes the delay line and taps and sets tap_count to 1.
// A finished result waits in the output register; the chain stalls only when
// that register is still full at the next result.
module fir_convolution_stream #(
  parameter int MAX_TAPS = fcs_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [fcs_pkg::IDX_W-1:0]           in_tap_index,
  input  logic signed [fcs_pkg::SAMPLE_W-1:0] in_value,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fcs_pkg::Y_W-1:0]      out_y,
  output logic                                out_last_output,
  input  logic                                cfg_we,
  input  logic [fcs_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int NW   = $clog2(MAX_TAPS + 1);
  localparam int CW   = $clog2(MAX_TAPS + 2);
  localparam int CMPW = fcs_pkg::CFG_W + 1;
  localparam logic [CW-1:0] CNT_DONE = CW'(MAX_TAPS + 1);

  fcs_pkg::state_t      state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        tail_r, tail_nxt;
  logic                 last_r, last_nxt;
  logic [fcs_pkg::CFG_W-1:0] tap_count_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [fcs_pkg::Y_W-1:0] out_y_r, out_y_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [NW-1:0]        n_taps;
  logic                 accept;
  logic                 out_free;
  logic                 capture;
  fcs_pkg::cell_ctrl_t  ctrl;

  logic signed [fcs_pkg::SAMPLE_W-1:0] s_in   [MAX_TAPS];
  logic signed [fcs_pkg::Y_W-1:0]      acc_in [MAX_TAPS];
  logic signed [fcs_pkg::Y_W-1:0]      acc_last;
  logic [MAX_TAPS-1:0]                 tap_en;

  // zero means one tap, above the chain length saturates
  always_comb begin
    if (tap_count_r == '0) begin
      n_taps = NW'(1);
    end else if ({1'b0, tap_count_r} > CMPW'(MAX_TAPS)) begin
      n_taps = NW'(MAX_TAPS);
    end else begin
      n_taps = NW'(tap_count_r);
    end
  end

  assign in_stall = (state_r != fcs_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign capture  = (state_r == fcs_pkg::ST_RUN) && (cnt_r == CNT_DONE) && out_free;

  always_comb begin
    ctrl.shift    = (accept && (in_kind == fcs_pkg::KIND_SAMPLE)) ||
                    (capture && (tail_r != '0));
    ctrl.clear    = capture && (tail_r == '0) && last_r;
    ctrl.coef_we  = accept && (in_kind == fcs_pkg::KIND_COEF);
    ctrl.coef_idx = in_tap_index;
    ctrl.coef     = in_value;
  end

  // tail items shift in zeros
  assign s_in[0]   = accept ? in_value : '0;
  assign acc_in[0] = '0;

  genvar j;
  generate
    for (j = 0; j < MAX_TAPS; j++) begin : g_cell
      assign tap_en[j] = (NW'(j) < n_taps);
      if (j < MAX_TAPS - 1) begin : g_mid
        fcs_cell #(.INDEX(j)) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctrl    (ctrl),
          .tap_en  (tap_en[j]),
          .s_in    (s_in[j]),
          .s_out   (s_in[j+1]),
          .acc_in  (acc_in[j]),
          .acc_out (acc_in[j+1])
        );
      end else begin : g_end
        fcs_cell #(.INDEX(j)) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctrl    (ctrl),
          .tap_en  (tap_en[j]),
          .s_in    (s_in[j]),
          .s_out   (),
          .acc_in  (acc_in[j]),
          .acc_out (acc_last)
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fcs_pkg::ST_IDLE: begin
        if (accept && (in_kind == fcs_pkg::KIND_SAMPLE)) begin
          state_nxt = fcs_pkg::ST_RUN;
          cnt_nxt   = '0;
          last_nxt  = in_last_sample;
          tail_nxt  = in_last_sample ? n_taps - NW'(1) : '0;
        end
      end
      fcs_pkg::ST_RUN: begin
        if (cnt_r != CNT_DONE) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (capture) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = acc_last;
          out_last_nxt  = last_r && (tail_r == '0);
          if (tail_r != '0) begin
            tail_nxt = tail_r - NW'(1);
            cnt_nxt  = '0;
          end else begin
            state_nxt = fcs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcs_pkg::ST_IDLE;
      cnt_r       <= '0;
      tail_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      tap_count_r <= fcs_pkg::CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_y           = out_y_r;
  assign out_last_output = out_last_r;

`ifndef SYNTHESIS
  a_tail_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (capture && (tail_r != '0)) |=> (state_r == fcs_pkg::ST_RUN) && (cnt_r == '0))
    else $error("tail item did not restart the chain");

  a_clear_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (out_valid_r && out_last_r))
    else $error("delay line cleared without a final item");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcs_pkg::ST_RUN) |-> (tail_r < n_taps))
    else $error("tail count exceeds taps in use");

  a_idle_no_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcs_pkg::ST_IDLE) |-> (tail_r == '0))
    else $error("idle with tail items pending");
`endif

endmodule

// File: verif/fir_convolution_stream_test.sv
`timescale 1ns / 1ps
module fir_convolution_stream_test;
  import fcs_pkg::*;

  localparam int NTAPS      = MAX_TAPS_DEF;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = NTAPS + 12;
  localparam int RAND_ITEMS = 80;

  typedef struct packed {
    logic                       kind;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } conv_item_t;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic                  last;
  } conv_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_kind = KIND_COEF;
  logic [IDX_W-1:0]           in_tap_index = '0;
  logic signed [SAMPLE_W-1:0] in_value = '0;
  logic                       in_last_sample = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [Y_W-1:0]      out_y;
  logic                       out_last_output;
  logic                       cfg_we = 1'b0;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  fir_convolution_stream #(.MAX_TAPS(NTAPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_tap_index(in_tap_index), .in_value(in_value), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_y(out_y),
    .out_last_output(out_last_output),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic signed [SAMPLE_W-1:0] taps[NTAPS];
  logic signed [SAMPLE_W-1:0] dline[NTAPS-1];
  logic [CFG_W-1:0]           tap_cfg = 6'd1;

  conv_item_t   conv_pend[$];
  conv_result_t conv_expect[$];
  int           mismatches = 0;

  // pacing controls, written only by the stimulus process
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit long_hold_on = 1'b0;

  initial begin
    for (int i = 0; i < NTAPS; i++) taps[i] = '0;
    for (int i = 0; i < NTAPS - 1; i++) dline[i] = '0;
  end

  function automatic int active_taps();
    if (tap_cfg == 0) return 1;
    if (int'(tap_cfg) > NTAPS) return NTAPS;
    return int'(tap_cfg);
  endfunction

  function automatic logic signed [Y_W-1:0] conv_shift_sum(logic signed [SAMPLE_W-1:0] x,
                                                           int n);
    longint acc;
    acc = longint'(taps[0]) * longint'(x);
    for (int j = 1; j < n; j++) acc += longint'(taps[j]) * longint'(dline[j-1]);
    for (int j = NTAPS - 2; j > 0; j--) dline[j] = dline[j-1];
    dline[0] = x;
    return acc[Y_W-1:0];
  endfunction

  task automatic conv_predict(input conv_item_t it);
    int n;
    int cnt;
    conv_result_t r;
    if (it.kind == KIND_COEF) begin
      if (int'(it.idx) < NTAPS) taps[it.idx] = it.value;
      return;
    end
    n = active_taps();
    cnt = it.last ? n : 1;
    for (int k = 0; k < cnt; k++) begin
      r.y = conv_shift_sum((k == 0) ? it.value : '0, n);
      r.last = it.last && (k == cnt - 1);
      conv_expect.push_back(r);
    end
    // a finished signal leaves an empty line
    if (it.last)
      for (int i = 0; i < NTAPS - 1; i++) dline[i] = '0;
  endtask

  // sender
  conv_item_t tx_cur;
  int         tx_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        conv_predict(tx_cur);
        tx_gap = tx_burst ? 0 : $urandom_range(0, 8);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0 || conv_pend.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_valid <= 1'b0;
        end else begin
          tx_cur = conv_pend.pop_front();
          in_valid <= 1'b1;
          in_kind <= tx_cur.kind;
          in_tap_index <= tx_cur.idx;
          in_value <= tx_cur.value;
          in_last_sample <= tx_cur.last;
        end
      end
    end
  end

  // receiver and checker
  int rx_wait;
  int long_hold_cnt;

  always @(posedge clk) begin
    conv_result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      long_hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (conv_expect.size() == 0) begin
          $display("%0t: unexpected item y %0d last %0b", $time, out_y, out_last_output);
          mismatches++;
        end else begin
          exp_r = conv_expect.pop_front();
          if (out_y !== exp_r.y) begin
            $display("%0t: y expected %0d got %0d", $time, exp_r.y, out_y);
            mismatches++;
          end
          if (out_last_output !== exp_r.last) begin
            $display("%0t: last_output expected %0b got %0b", $time, exp_r.last,
                     out_last_output);
            mismatches++;
          end
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (long_hold_on && long_hold_cnt < LONG_HOLD) begin
        long_hold_cnt++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_wait != 0);
      end
    end
  end

  task automatic queue_item(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] value, input logic last);
    conv_item_t it;
    it.kind = kind;
    it.idx = idx;
    it.value = value;
    it.last = last;
    conv_pend.push_back(it);
  endtask

  // wait for every outstanding item to come back, then let the chain settle
  task automatic drain();
    while (conv_pend.size() != 0 || in_valid || conv_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tap_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_cfg[7];
    int n_queued;
    int len;
    int phase_items;
    phase_cfg = '{6'd2, 6'd32, 6'd5, 6'd63, 6'd0, 6'd17, 6'd1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single tap from reset, all taps zero
    queue_item(KIND_SAMPLE, 5'd31, 16'sh7fff, 1'b0);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh8000, 1'b1);
    // last mark on a tap load is ignored
    queue_item(KIND_COEF, 5'd0, 16'sh8000, 1'b1);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh8000, 1'b0);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh7fff, 1'b1);
    drain();

    // zero tap count behaves as one tap
    write_tap_count(6'd0);
    queue_item(KIND_COEF, 5'd0, 16'sh7fff, 1'b0);
    queue_item(KIND_SAMPLE, 5'd7, 16'sh8000, 1'b1);
    drain();

    // oversize count saturates to the full chain
    write_tap_count(6'd63);
    queue_item(KIND_COEF, 5'd31, 16'sh8000, 1'b0);
    queue_item(KIND_COEF, 5'd1, 16'sh7fff, 1'b0);
    queue_item(KIND_COEF, 5'd16, 16'shffff, 1'b0);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh8000, 1'b0);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh8000, 1'b0);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh7fff, 1'b1);
    // tap count changed with a signal in flight
    queue_item(KIND_SAMPLE, 5'd0, 16'sd1234, 1'b0);
    drain();
    write_tap_count(6'd3);
    queue_item(KIND_SAMPLE, 5'd0, 16'shffff, 1'b1);
    drain();
    write_tap_count(6'd32);
    queue_item(KIND_SAMPLE, 5'd0, 16'sh8000, 1'b1);
    drain();

    // receiver holds off while the sender keeps going
    tx_burst = 1'b1;
    long_hold_on = 1'b1;
    for (int k = 0; k < 20; k++)
      queue_item(KIND_SAMPLE, IDX_W'($urandom), rand_value(), (k % 5) == 4);
    drain();
    tx_burst = 1'b0;

    n_queued = 0;
    for (int p = 0; p < 7 && n_queued < RAND_ITEMS; p++) begin
      if (p == 2 || p == 5) phase_cfg[p] = CFG_W'($urandom_range(3, 31));
      write_tap_count(phase_cfg[p]);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < 19) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            queue_item(KIND_COEF, IDX_W'($urandom), rand_value(), 1'($urandom));
            phase_items++;
          end
        end
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          // now and then a signal is left open into the next one
          queue_item(KIND_SAMPLE, IDX_W'($urandom), rand_value(),
                     (k == len - 1) && ($urandom_range(0, 7) != 0));
          phase_items++;
          // stray tap update inside a signal
          if ($urandom_range(0, 15) == 0) begin
            queue_item(KIND_COEF, IDX_W'($urandom), rand_value(), 1'b0);
            phase_items++;
          end
        end
      end
      n_queued += phase_items;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
